// ===== hdl/box_blur_3x3_edge_aware_top_macros.svh =====
// Assertion macros for the box blur RTL.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BBEA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbea: implication check failed");
// Invariant checked at every clock edge out of reset.
`define BBEA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bbea: invariant check failed");
`else
`define BBEA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BBEA_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/bbea_pkg.sv =====
// Types, constants and the reciprocal table of the 3x3 box blur.
`timescale 1ns / 1ps
package bbea_pkg;

    localparam int PIX_CH_W     = 8;
    localparam int SUM_W        = 12;   // nine 8-bit taps
    localparam int CNT_W        = 4;    // up to nine taps
    localparam int NUM_W        = 13;   // 2*sum + count
    localparam int RECIP_W      = 17;
    localparam int RECIP_SHIFT  = 17;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 768;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 1'b0;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_CH_W-1:0] red;
        logic [PIX_CH_W-1:0] green;
        logic [PIX_CH_W-1:0] blue;
    } t_pix;

    // Window row k holds rows r-2..r, column m holds columns c-2..c.
    typedef t_pix [2:0][2:0] t_win;

    typedef struct packed {
        logic [PIX_CH_W-1:0] in_red;
        logic [PIX_CH_W-1:0] in_green;
        logic [PIX_CH_W-1:0] in_blue;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_CH_W-1:0] out_red;
        logic [PIX_CH_W-1:0] out_green;
        logic [PIX_CH_W-1:0] out_blue;
        logic                last_in_run;
        logic                frame_done;
    } t_out_beat;

    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } t_tap_mask;

    typedef struct packed {
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
        logic [CNT_W-1:0] cnt;
    } t_sums;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SUM,
        ST_PUT
    } t_state;

    // ceil(2^17 / (2*cnt)); exact floor division for numerators below 4600.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] rv;
        case (cnt)
            4'd2:    rv = 17'd32768;
            4'd3:    rv = 17'd21846;
            4'd4:    rv = 17'd16384;
            4'd5:    rv = 17'd13108;
            4'd6:    rv = 17'd10923;
            4'd7:    rv = 17'd9363;
            4'd8:    rv = 17'd8192;
            4'd9:    rv = 17'd7282;
            default: rv = 17'd65536;
        endcase
        return rv;
    endfunction

endpackage

// ===== hdl/box_blur_3x3_edge_aware_top.sv =====
// Top level of the streaming 3x3 edge-aware RGB box blur.
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_aware_top_macros.svh"
// Usage:
//   Pixels enter in raster order on the input channel (i_in_valid / o_in_stall,
//   payload i_in_data). Blurred pixels leave on the output channel
//   (o_out_valid / i_out_stall, payload o_out_data). A beat moves at an edge
//   where valid is high and stall is low.
//   Each input releases 0 to 4 outputs, in raster order; last_in_run marks
//   the final one of them, frame_done the pixel at the last row and column.
//   Sequencing: an input occupies the sequencer for the line memory read, then
//   for write-back and window shift, then for a sum step and an output step
//   per released output through the shared sum and reciprocal-multiply
//   unit. The first output is registered after the LOOK, SUM and PUT states.
//   A finished output waits in the output register; the next input is taken
//   while it waits. When the receiver stalls and the register is full, the
//   sequencer holds in its output step and o_in_stall stays high.
//   Configuration: index 0 = image width, index 1 = image height, written
//   only while the block is idle; any write restarts the frame at (0,0).
//   Reset: width 1024, height 768 (clamped to the parameters), window cleared,
//   position (0,0). The line memory is not cleared: entries above row 0 are
//   only ever used once written in the current frame.
module box_blur_3x3_edge_aware_top import bbea_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    // blurred output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (MAX_WIDTH  < RESET_WIDTH)  ? MAX_WIDTH  : RESET_WIDTH;
    localparam int RST_H = (MAX_HEIGHT < RESET_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
    localparam int PIX_W = 3 * PIX_CH_W;
    localparam int PROD_W = NUM_W + RECIP_W;

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    t_state         r_state, n_state;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [WW-1:0]  r_width;
    logic [HW-1:0]  r_height;
    logic [3:0]     r_pend;       // outputs still to produce for this beat
    logic           r_out_valid;
    t_win           r_win;

    // Per-beat context captured at accept
    t_pix           r_pix;
    logic [CW-1:0]  r_addr;
    logic           r_ge1, r_ge2, r_c_ge1, r_c_ge2;
    logic           r_last, r_fd;
    t_out_beat      r_out;

    // Line memory: {row two above, row above} per column
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_mem_rd;

    // Sequencer strobes
    logic in_accept, cfg_accept;
    logic mem_we, sum_load, out_load;

    // ---------------------------------------------------------------------
    // Position bookkeeping
    // ---------------------------------------------------------------------
    logic          col_last, row_last;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [3:0]    n_pend;

    always_comb begin
        col_last = (WW'(r_col) + WW'(1)) == r_width;
        row_last = (HW'(r_row) + HW'(1)) == r_height;
        n_col    = col_last ? '0 : r_col + CW'(1);
        n_row    = r_row;
        if (col_last) begin
            n_row = row_last ? '0 : r_row + RW'(1);
        end
        // Candidates in raster order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
        n_pend[0] = (r_row != '0) && (r_col != '0);
        n_pend[1] = (r_row != '0) && col_last;
        n_pend[2] = row_last && (r_col != '0);
        n_pend[3] = row_last && col_last;
    end

    // ---------------------------------------------------------------------
    // Configuration clamp: zero reads as one, large values saturate
    // ---------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  cfg_w_raw;
    logic [CFG_HEIGHT_W-1:0] cfg_h_raw;
    logic [WW-1:0]           cfg_width;
    logic [HW-1:0]           cfg_height;

    always_comb begin
        cfg_w_raw = i_cfg_data[CFG_WIDTH_W-1:0];
        cfg_h_raw = i_cfg_data[CFG_HEIGHT_W-1:0];
        if (cfg_w_raw == '0) begin
            cfg_width = WW'(1);
        end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
            cfg_width = WW'(MAX_WIDTH);
        end else begin
            cfg_width = WW'(cfg_w_raw);
        end
        if (cfg_h_raw == '0) begin
            cfg_height = HW'(1);
        end else if (32'(cfg_h_raw) > 32'(MAX_HEIGHT)) begin
            cfg_height = HW'(MAX_HEIGHT);
        end else begin
            cfg_height = HW'(cfg_h_raw);
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = (r_pend != '0) ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (out_load) begin
                    n_state = (r_pend != '0) ? ST_SUM : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: strobes
    // ---------------------------------------------------------------------
    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        mem_we      = 1'b0;
        sum_load    = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = 1'b1;
            end
            ST_LOOK: begin
                mem_we = 1'b1;
            end
            ST_SUM: begin
                sum_load = 1'b1;
            end
            ST_PUT: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        in_accept  = i_in_valid && !o_in_stall;
        cfg_accept = i_cfg_valid && o_cfg_ready;
    end

    // ---------------------------------------------------------------------
    // Pick the next pending output and build its tap mask
    // ---------------------------------------------------------------------
    logic [1:0] pick_idx;
    logic [3:0] pend_left;
    t_tap_mask  tap_mask;

    always_comb begin
        if (r_pend[0]) begin
            pick_idx = 2'd0;
        end else if (r_pend[1]) begin
            pick_idx = 2'd1;
        end else if (r_pend[2]) begin
            pick_idx = 2'd2;
        end else begin
            pick_idx = 2'd3;
        end
        pend_left = r_pend & ~(4'b0001 << pick_idx);
        // Window row 0 is row r-2: only inside the image for the upper output
        // when r >= 2; row 1 is r-1, inside once r >= 1; row 2 always.
        tap_mask.row_ok = {1'b1, r_ge1, !pick_idx[1] && r_ge2};
        tap_mask.col_ok = {1'b1, r_c_ge1, !pick_idx[0] && r_c_ge2};
    end

    t_sums sums;

    bbea_tap_sum u_tap_sum (
        .i_clk  (i_clk),
        .i_load (sum_load),
        .i_win  (r_win),
        .i_mask (tap_mask),
        .o_sums (sums)
    );

    // ---------------------------------------------------------------------
    // Rounded mean: floor((2*sum + cnt) / (2*cnt)) by exact reciprocal
    // ---------------------------------------------------------------------
    logic [RECIP_W-1:0] recip;
    logic [NUM_W-1:0]   num_r, num_g, num_b;
    logic [PROD_W-1:0]  prod_r, prod_g, prod_b;

    always_comb begin
        recip  = recip_of(sums.cnt);
        num_r  = {sums.red_sum,   1'b0} + NUM_W'(sums.cnt);
        num_g  = {sums.green_sum, 1'b0} + NUM_W'(sums.cnt);
        num_b  = {sums.blue_sum,  1'b0} + NUM_W'(sums.cnt);
        prod_r = PROD_W'(num_r) * PROD_W'(recip);
        prod_g = PROD_W'(num_g) * PROD_W'(recip);
        prod_b = PROD_W'(num_b) * PROD_W'(recip);
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_width     <= WW'(RST_W);
            r_height    <= HW'(RST_H);
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_accept) begin
                // Any register write restarts the frame.
                r_col <= '0;
                r_row <= '0;
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= cfg_width;
                    CFG_IMAGE_HEIGHT: r_height <= cfg_height;
                    default:          r_width  <= r_width;
                endcase
            end else if (in_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_accept) begin
                r_pend <= n_pend;
            end else if (sum_load) begin
                r_pend <= pend_left;
            end
            if (mem_we) begin
                // Shift the window left and bring in the new column.
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= r_mem_rd[2*PIX_W-1:PIX_W];
                r_win[1][2] <= r_mem_rd[PIX_W-1:0];
                r_win[2][2] <= r_pix;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers and line memory
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix   <= t_pix'(i_in_data);
            r_addr  <= r_col;
            r_ge1   <= r_row != '0;
            r_ge2   <= r_row > RW'(1);
            r_c_ge1 <= r_col != '0;
            r_c_ge2 <= r_col > CW'(1);
        end
        if (sum_load) begin
            r_last <= pend_left == '0;
            r_fd   <= pick_idx == 2'd3;
        end
        if (out_load) begin
            r_out.out_red     <= prod_r[RECIP_SHIFT +: PIX_CH_W];
            r_out.out_green   <= prod_g[RECIP_SHIFT +: PIX_CH_W];
            r_out.out_blue    <= prod_b[RECIP_SHIFT +: PIX_CH_W];
            r_out.last_in_run <= r_last;
            r_out.frame_done  <= r_fd;
        end
    end

    // Read on accept, write back {row above, new pixel} in the following cycle.
    // The next read is issued only after the write, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mem_rd <= r_line_mem[r_col];
        end
        if (mem_we) begin
            r_line_mem[r_addr] <= {r_mem_rd[PIX_W-1:0], r_pix};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `BBEA_ASSERT_IMPLY(a_idle_no_pend, i_clk, i_rst_n, r_state == ST_IDLE, r_pend == '0)
    `BBEA_ASSERT_IMPLY(a_put_cnt_nonzero, i_clk, i_rst_n, r_state == ST_PUT, sums.cnt != '0)
    `BBEA_ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_out_data.frame_done, o_out_data.last_in_run)
    `BBEA_ASSERT_ALWAYS(a_col_in_frame, i_clk, i_rst_n, WW'(r_col) < r_width)
    `BBEA_ASSERT_ALWAYS(a_row_in_frame, i_clk, i_rst_n, HW'(r_row) < r_height)

endmodule

// ===== hdl/bbea_tap_sum.sv =====
// Masked per-channel sum and tap count over the 3x3 window, registered.
`timescale 1ns / 1ps
module bbea_tap_sum import bbea_pkg::*; (
    input  logic      i_clk,
    input  logic      i_load,
    input  t_win      i_win,
    input  t_tap_mask i_mask,
    output t_sums     o_sums
);

    t_sums n_sums;
    t_sums r_sums;

    // Sum the taps that lie inside both the image and the window.
    always_comb begin
        n_sums = '0;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                if (i_mask.row_ok[k] && i_mask.col_ok[m]) begin
                    n_sums.red_sum   = n_sums.red_sum   + SUM_W'(i_win[k][m].red);
                    n_sums.green_sum = n_sums.green_sum + SUM_W'(i_win[k][m].green);
                    n_sums.blue_sum  = n_sums.blue_sum  + SUM_W'(i_win[k][m].blue);
                    n_sums.cnt       = n_sums.cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule
